// ===== rtl/hcp_pkg.sv =====
package hcp_pkg;

    localparam int CELLS  = 16;
    localparam int CB     = $clog2(CELLS);
    localparam int PW     = 12;
    localparam int CW     = 12;
    localparam int XW     = PW + 1;
    localparam int PRW    = XW + CW;
    localparam int SUMW   = PRW + 1;
    localparam int MAGW   = SUMW;
    localparam int DW     = 2 * CW + 1;
    localparam int COMPW  = 5;
    localparam int COLW   = 3 * COMPW;
    localparam int AW     = 4;
    localparam int DATAW  = 32;

    localparam logic [1:0] REG_AREA_WIDTH  = 2'd0;
    localparam logic [1:0] REG_AREA_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DARK_CENTRE = 2'd2;

    localparam logic [CW-1:0] AREA_RESET = CW'(128);

    typedef struct packed {
        logic          ovf;
        logic [CB-1:0] q;
    } div_res_t;

    // colour component for cell index k: 31*k/(CELLS-1), selected from constants
    function automatic logic [COMPW-1:0] comp(input logic [CB-1:0] k);
        int v;
        v = 0;
        for (int n = 0; n < CELLS; n++)
        begin
            if (k == CB'(n))
                v = (31 * n) / (CELLS - 1);
        end
        return v[COMPW-1:0];
    endfunction

endpackage

// ===== rtl/hexagon_color_picker_hit_test_unit.sv =====
// channel | handshake                  | payload
// in      | in_valid / in_stall        | pos_x, pos_y
// out     | out_valid / out_stall      | hit, colour
// cfg     | psel penable pwrite pready | paddr, pwdata, prdata
//
// one point per cycle while out is not stalled; each point passes through every stage register before out_valid
// the five face divisions run as two radix-2 steps per stage
// rst_n clears the valid bits and loads the register reset values
// a stall on out freezes each stage holding a transaction with no bubble after it; bubbles still fill
// face constants follow a register write through height_reg, then a_reg, h_reg and r_reg
module hexagon_color_picker_hit_test_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [hcp_pkg::PW-1:0]        pos_x,
    input  logic [hcp_pkg::PW-1:0]        pos_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic [hcp_pkg::COLW-1:0]      colour,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hcp_pkg::AW-1:0]        paddr,
    input  logic [hcp_pkg::DATAW-1:0]     pwdata,
    output logic [hcp_pkg::DATAW-1:0]     prdata,
    output logic                          pready
);

    localparam int CW = hcp_pkg::CW;
    localparam int XW = hcp_pkg::XW;

    logic [CW-1:0] width_reg;
    logic [CW-1:0] height_reg;
    logic          dark_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= hcp_pkg::AREA_RESET;
            height_reg <= hcp_pkg::AREA_RESET;
            dark_reg   <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                hcp_pkg::REG_AREA_WIDTH:  width_reg  <= pwdata[CW-1:0];
                hcp_pkg::REG_AREA_HEIGHT: height_reg <= pwdata[CW-1:0];
                hcp_pkg::REG_DARK_CENTRE: dark_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            hcp_pkg::REG_AREA_WIDTH:  prdata = hcp_pkg::DATAW'(width_reg);
            hcp_pkg::REG_AREA_HEIGHT: prdata = hcp_pkg::DATAW'(height_reg);
            hcp_pkg::REG_DARK_CENTRE: prdata = hcp_pkg::DATAW'(dark_reg);
            default:                  prdata = '0;
        endcase
    end

    // face constants: a, h = a/2, r = (17a/10)/2 = 17a/20, all toward zero
    logic signed [CW-1:0] a_c;
    logic signed [CW-1:0] a_plus;
    logic signed [CW-1:0] h_c;
    logic signed [16:0]   t_c;
    logic [15:0]          t_mag;
    logic [30:0]          t_prod;
    logic [12:0]          t_q;
    logic signed [CW-1:0] r_c;
    logic signed [CW-1:0] a_reg;
    logic signed [CW-1:0] h_reg;
    logic signed [CW-1:0] r_reg;

    always_comb
    begin
        a_c    = $signed({1'b0, height_reg[CW-1:1]}) - CW'(2);
        a_plus = a_c + CW'(a_c[CW-1]);
        h_c    = a_plus >>> 1;
        t_c    = (17'(a_c) <<< 4) + 17'(a_c);
        t_mag  = t_c[16] ? 16'(-t_c) : t_c[15:0];
        // divide by 20: shift by two, then times 52429 >> 18 for /5
        t_prod = 31'(t_mag[15:2]) * 31'(52429);
        t_q    = t_prod[30:18];
        r_c    = t_c[16] ? -CW'(t_q) : CW'(t_q);
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_c;
        h_reg <= h_c;
        r_reg <= r_c;
    end

    logic signed [2*CW-1:0]      rh_c;
    logic signed [2*CW-1:0]      ra_c;
    logic [hcp_pkg::DW-1:0]      d1_reg;
    logic [hcp_pkg::DW-1:0]      d2_reg;
    logic                        rh_neg_reg;
    logic                        rh_zero_reg;
    logic                        ra_neg_reg;
    logic                        ra_zero_reg;

    assign rh_c = (2*CW)'(r_reg) * (2*CW)'(h_reg);
    assign ra_c = (2*CW)'(r_reg) * (2*CW)'(a_reg);

    always_ff @(posedge clk)
    begin
        d1_reg      <= rh_c[2*CW-1] ? hcp_pkg::DW'(-rh_c) << 1 : hcp_pkg::DW'(rh_c) << 1;
        d2_reg      <= ra_c[2*CW-1] ? hcp_pkg::DW'(-ra_c) : hcp_pkg::DW'(ra_c);
        rh_neg_reg  <= rh_c[2*CW-1];
        rh_zero_reg <= (rh_c == '0);
        ra_neg_reg  <= ra_c[2*CW-1];
        ra_zero_reg <= (ra_c == '0);
    end

    // pipeline control
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;

    assign en6      = !v6_reg || !out_stall;
    assign en5      = !v5_reg || en6;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // stage 1: move to the widget centre
    logic signed [XW-1:0] x1_reg;
    logic signed [XW-1:0] y1_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            x1_reg <= XW'($signed(pos_x)) - $signed({2'b0, width_reg[CW-1:1]});
            y1_reg <= XW'($signed(pos_y)) - $signed({2'b0, height_reg[CW-1:1]});
        end
    end

    // stage 2: products x*h, y*r, x*a
    logic signed [hcp_pkg::PRW-1:0] pa_reg;
    logic signed [hcp_pkg::PRW-1:0] pb_reg;
    logic signed [hcp_pkg::PRW-1:0] pc_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            pa_reg <= hcp_pkg::PRW'(x1_reg) * hcp_pkg::PRW'(h_reg);
            pb_reg <= hcp_pkg::PRW'(y1_reg) * hcp_pkg::PRW'(r_reg);
            pc_reg <= hcp_pkg::PRW'(x1_reg) * hcp_pkg::PRW'(a_reg);
        end
    end

    // stage 3: numerator magnitudes and signs
    logic signed [hcp_pkg::SUMW-1:0] s_m;
    logic signed [hcp_pkg::SUMW-1:0] s_p;
    logic signed [hcp_pkg::SUMW-1:0] s_c;
    logic [hcp_pkg::MAGW-1:0]        m1_reg, m2_reg, m3_reg;
    logic                            n1_reg, n2_reg, n3_reg;

    assign s_m = hcp_pkg::SUMW'(pa_reg) - hcp_pkg::SUMW'(pb_reg);
    assign s_p = hcp_pkg::SUMW'(pa_reg) + hcp_pkg::SUMW'(pb_reg);
    assign s_c = hcp_pkg::SUMW'(pc_reg);

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            m1_reg <= s_m[hcp_pkg::SUMW-1] ? hcp_pkg::MAGW'(-s_m) : hcp_pkg::MAGW'(s_m);
            m2_reg <= s_p[hcp_pkg::SUMW-1] ? hcp_pkg::MAGW'(-s_p) : hcp_pkg::MAGW'(s_p);
            m3_reg <= s_c[hcp_pkg::SUMW-1] ? hcp_pkg::MAGW'(-s_c) : hcp_pkg::MAGW'(s_c);
            n1_reg <= s_m[hcp_pkg::SUMW-1];
            n2_reg <= s_p[hcp_pkg::SUMW-1];
            n3_reg <= s_c[hcp_pkg::SUMW-1];
        end
    end

    // stages 4 and 5: divisions, signs travel alongside
    logic [2:0] sg4_reg, sg5_reg;

    always_ff @(posedge clk)
    begin
        if (en4) sg4_reg <= {n3_reg, n2_reg, n1_reg};
        if (en5) sg5_reg <= sg4_reg;
    end

    hcp_pkg::div_res_t q_red_i, q_red_j, q_c, q_grn_j, q_blu_i;

    hcp_div u_div_red_i (.clk(clk), .en_a(en4), .en_b(en5), .mag(m1_reg), .den(d1_reg),
                         .res(q_red_i));
    hcp_div u_div_red_j (.clk(clk), .en_a(en4), .en_b(en5), .mag(m2_reg), .den(d1_reg),
                         .res(q_red_j));
    // green i and blue j share the magnitude |x*a| / |r*a|
    hcp_div u_div_c     (.clk(clk), .en_a(en4), .en_b(en5), .mag(m3_reg), .den(d2_reg),
                         .res(q_c));
    hcp_div u_div_grn_j (.clk(clk), .en_a(en4), .en_b(en5), .mag(m1_reg), .den(d2_reg),
                         .res(q_grn_j));
    hcp_div u_div_blu_i (.clk(clk), .en_a(en4), .en_b(en5), .mag(m2_reg), .den(d2_reg),
                         .res(q_blu_i));

    // stage 6: face select and colour
    logic                        ok_ri, ok_rj, ok_gi, ok_gj, ok_bi, ok_bj;
    logic                        red_hit, grn_hit, blu_hit, any_hit;
    logic [hcp_pkg::COMPW-1:0]   rc, gc, bc;
    logic [hcp_pkg::COLW-1:0]    col;
    logic [hcp_pkg::COLW-1:0]    colour_next;
    logic                        hit_reg;
    logic [hcp_pkg::COLW-1:0]    colour_reg;

    // a negative quotient is in range only when it truncates to zero
    always_comb
    begin
        ok_ri = !q_red_i.ovf && (q_red_i.q == '0 || !(sg5_reg[0] ^ !rh_neg_reg));
        ok_rj = !q_red_j.ovf && (q_red_j.q == '0 || !(sg5_reg[1] ^ rh_neg_reg));
        ok_gi = !q_c.ovf     && (q_c.q == '0     || !(sg5_reg[2] ^ ra_neg_reg));
        ok_gj = !q_grn_j.ovf && (q_grn_j.q == '0 || !(sg5_reg[0] ^ ra_neg_reg));
        ok_bi = !q_blu_i.ovf && (q_blu_i.q == '0 || !(sg5_reg[1] ^ !ra_neg_reg));
        ok_bj = !q_c.ovf     && (q_c.q == '0     || !(!sg5_reg[2] ^ ra_neg_reg));

        red_hit = !rh_zero_reg && ok_ri && ok_rj;
        grn_hit = !ra_zero_reg && ok_gi && ok_gj;
        blu_hit = !ra_zero_reg && ok_bi && ok_bj;
        any_hit = red_hit || grn_hit || blu_hit;

        rc = '0;
        gc = '0;
        bc = '0;
        if (red_hit)
        begin
            gc = hcp_pkg::comp(q_red_i.q);
            bc = hcp_pkg::comp(q_red_j.q);
        end
        else if (grn_hit)
        begin
            bc = hcp_pkg::comp(q_c.q);
            rc = hcp_pkg::comp(q_grn_j.q);
        end
        else
        begin
            rc = hcp_pkg::comp(q_blu_i.q);
            gc = hcp_pkg::comp(q_c.q);
        end

        col = {bc, gc, rc};
        if (!any_hit)
            colour_next = '0;
        else if (dark_reg)
            colour_next = col;
        else
            colour_next = ~col;
    end

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            hit_reg    <= any_hit;
            colour_reg <= colour_next;
        end
    end

    assign out_valid = v6_reg;
    assign hit       = hit_reg;
    assign colour    = colour_reg;

endmodule

// ===== rtl/hcp_div.sv =====
module hcp_div
(
    input  logic                       clk,
    input  logic                       en_a,
    input  logic                       en_b,
    input  logic [hcp_pkg::MAGW-1:0]   mag,
    input  logic [hcp_pkg::DW-1:0]     den,
    output hcp_pkg::div_res_t          res
);

    localparam int NW = hcp_pkg::MAGW + hcp_pkg::CB;
    localparam int RW = hcp_pkg::DW + 1;
    localparam int SA = (hcp_pkg::CB + 1) / 2;

    logic [NW-1:0]            num;
    logic [RW-1:0]            rem_a;
    logic [hcp_pkg::CB-1:0]   q_a;
    logic                     ovf_a;
    logic [RW-1:0]            rem_reg;
    logic [hcp_pkg::CB-1:0]   q_reg;
    logic [hcp_pkg::CB-1:0]   nlow_reg;
    logic                     ovf_reg;
    logic [hcp_pkg::DW-1:0]   den_reg;
    logic [RW-1:0]            rem_b;
    logic [hcp_pkg::CB-1:0]   q_b;
    hcp_pkg::div_res_t        res_reg;

    // quotient reaches CELLS exactly when mag >= den
    always_comb
    begin
        num   = NW'(mag) * NW'(hcp_pkg::CELLS);
        ovf_a = (NW'(mag) >= NW'(den));
        rem_a = RW'(num >> hcp_pkg::CB);
        q_a   = '0;
        for (int k = 0; k < SA; k++)
        begin
            rem_a = {rem_a[RW-2:0], num[hcp_pkg::CB-1-k]};
            if (rem_a >= RW'(den))
            begin
                rem_a = rem_a - RW'(den);
                q_a[hcp_pkg::CB-1-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            rem_reg  <= rem_a;
            q_reg    <= q_a;
            nlow_reg <= num[hcp_pkg::CB-1:0];
            ovf_reg  <= ovf_a;
            den_reg  <= den;
        end
    end

    always_comb
    begin
        rem_b = rem_reg;
        q_b   = q_reg;
        for (int k = SA; k < hcp_pkg::CB; k++)
        begin
            rem_b = {rem_b[RW-2:0], nlow_reg[hcp_pkg::CB-1-k]};
            if (rem_b >= RW'(den_reg))
            begin
                rem_b = rem_b - RW'(den_reg);
                q_b[hcp_pkg::CB-1-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            res_reg.ovf <= ovf_reg;
            res_reg.q   <= q_b;
        end
    end

    assign res = res_reg;

endmodule
